FILE: rtl/core/pac_pkg.sv
// Package for the polygon area and centroid unit.
// Holds the sequencer states and the control and status bundles of the shared units.
// No dependencies.
package pac_pkg;

	localparam int AREA_W = 40;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CROSS,
		ST_CLOSE1,
		ST_CLOSE2,
		ST_DRAIN,
		ST_FIN,
		ST_DIVX,
		ST_DIVY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic en;
		logic sub;
		logic clr;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic neg;
	} div_stat_t;

endpackage

FILE: rtl/core/polygon_area_and_centroid_unit.sv
// Polygon area and centroid: a vertex beat is accepted, then the second cross product
// runs on the one shared multiplier. The last vertex closes the ring (CLOSE1, CLOSE2,
// DRAIN, FIN), then two serial divides of SW quotient bits each run (SW = COORD_WIDTH +
// clog2(MAX_VERTICES+1) + 1, 26 by default), and the OUT state loads the result beat.
// Reset (arst_n low, asynchronous) clears sequencer, sums, count, accumulator and out_valid.
module polygon_area_and_centroid_unit #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_WIDTH  = 16,
	localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic                          is_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pac_pkg::AREA_W-1:0]    twice_area,
	output logic signed [COORD_WIDTH-1:0] center_x,
	output logic signed [COORD_WIDTH-1:0] center_y,
	output logic [CNT_W-1:0]              vertex_count,
	output logic                          overflow
);

	localparam int CW      = COORD_WIDTH;
	localparam int AW      = pac_pkg::AREA_W;
	localparam int SW      = CW + CNT_W + 1;
	localparam int ACC_RAW = 2*CW + CNT_W + 1;
	localparam int ACC_W   = (ACC_RAW > AW) ? ACC_RAW : AW + 1;

	pac_pkg::state_t state_q, state_d;

	logic signed [CW-1:0]    first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic                    last_q, take_q, cross_q;
	logic signed [SW-1:0]    sum_x_q, sum_y_q;
	logic [CNT_W-1:0]        count_q;
	logic                    overflow_seen_q;
	logic [AW-1:0]           area_q;
	logic signed [CW-1:0]    cx_q;
	logic signed [CW-1:0]    cy_q;
	logic                    out_valid_q;

	logic                    in_acc;
	logic                    take;
	logic                    can_load;
	pac_pkg::mac_ctl_t       mac_ctl;
	logic signed [CW-1:0]    mac_a, mac_b;
	logic signed [ACC_W-1:0] acc;
	logic [ACC_W-1:0]        acc_mag;
	logic                    div_start;
	logic signed [SW-1:0]    div_dividend;
	logic [CNT_W-1:0]        div_divisor;
	logic [SW-1:0]           div_quo;
	pac_pkg::div_stat_t      div_stat;
	logic [CW-1:0]           quo_lo;
	logic signed [CW-1:0]    quo_signed;

	assign in_acc   = in_valid && !in_stall;
	assign take     = (count_q < CNT_W'(MAX_VERTICES));
	assign can_load = !out_valid_q || !out_stall;
	assign acc_mag  = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
	assign quo_lo   = div_quo[CW-1:0];
	assign quo_signed = div_stat.neg ? (~quo_lo + CW'(1)) : quo_lo;
	assign div_divisor = (count_q == '0) ? CNT_W'(1) : count_q;

	pac_mac #(.CW(CW), .ACC_W(ACC_W)) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.op_a  (mac_a),
		.op_b  (mac_b),
		.acc   (acc)
	);

	pac_div #(.SW(SW), .CNT_W(CNT_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.quotient(div_quo),
		.stat    (div_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pac_pkg::ST_IDLE:   if (in_acc) state_d = pac_pkg::ST_CROSS;
			pac_pkg::ST_CROSS:  state_d = last_q ? pac_pkg::ST_CLOSE1 : pac_pkg::ST_IDLE;
			pac_pkg::ST_CLOSE1: state_d = pac_pkg::ST_CLOSE2;
			pac_pkg::ST_CLOSE2: state_d = pac_pkg::ST_DRAIN;
			pac_pkg::ST_DRAIN:  state_d = pac_pkg::ST_FIN;
			pac_pkg::ST_FIN:    state_d = pac_pkg::ST_DIVX;
			pac_pkg::ST_DIVX:   if (div_stat.done) state_d = pac_pkg::ST_DIVY;
			pac_pkg::ST_DIVY:   if (div_stat.done) state_d = pac_pkg::ST_OUT;
			pac_pkg::ST_OUT:    if (can_load) state_d = pac_pkg::ST_IDLE;
			default:            state_d = pac_pkg::ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		mac_ctl      = '0;
		mac_a        = prev_x_q;
		mac_b        = prev_y_q;
		div_start    = 1'b0;
		div_dividend = sum_x_q;
		in_stall     = 1'b1;
		case (state_q)
			pac_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				mac_a      = prev_x_q;
				mac_b      = vertex_y;
				mac_ctl.en = in_acc && take && (count_q != '0);
			end
			pac_pkg::ST_CROSS: begin
				mac_a       = cur_x_q;
				mac_b       = prev_y_q;
				mac_ctl.en  = cross_q;
				mac_ctl.sub = 1'b1;
			end
			pac_pkg::ST_CLOSE1: begin
				mac_a      = prev_x_q;
				mac_b      = first_y_q;
				mac_ctl.en = 1'b1;
			end
			pac_pkg::ST_CLOSE2: begin
				mac_a       = first_x_q;
				mac_b       = prev_y_q;
				mac_ctl.en  = 1'b1;
				mac_ctl.sub = 1'b1;
			end
			pac_pkg::ST_FIN: begin
				mac_ctl.clr = 1'b1;
				div_start   = 1'b1;
			end
			pac_pkg::ST_DIVX: begin
				div_start    = div_stat.done;
				div_dividend = sum_y_q;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// polygon accumulation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q         <= '0;
			sum_y_q         <= '0;
			count_q         <= '0;
			overflow_seen_q <= 1'b0;
			last_q          <= 1'b0;
			take_q          <= 1'b0;
			cross_q         <= 1'b0;
		end else if (in_acc) begin
			last_q  <= is_last;
			take_q  <= take;
			cross_q <= take && (count_q != '0);
			if (take) begin
				sum_x_q <= sum_x_q + SW'(vertex_x);
				sum_y_q <= sum_y_q + SW'(vertex_y);
				count_q <= count_q + CNT_W'(1);
			end else begin
				overflow_seen_q <= 1'b1;
			end
		end else if (state_q == pac_pkg::ST_OUT && can_load) begin
			sum_x_q         <= '0;
			sum_y_q         <= '0;
			count_q         <= '0;
			overflow_seen_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_x_q <= vertex_x;
			cur_y_q <= vertex_y;
			if (take && count_q == '0) begin
				first_x_q <= vertex_x;
				first_y_q <= vertex_y;
			end
		end
		// advance the previous vertex only after both cross products have used it
		if (state_q == pac_pkg::ST_CROSS && take_q) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (state_q == pac_pkg::ST_FIN) begin
			area_q <= (|acc_mag[ACC_W-1:AW]) ? {AW{1'b1}} : acc_mag[AW-1:0];
		end
		if (state_q == pac_pkg::ST_DIVX && div_stat.done) begin
			cx_q <= quo_signed;
		end
		if (state_q == pac_pkg::ST_DIVY && div_stat.done) begin
			cy_q <= quo_signed;
		end
	end

	// result register: hold until the beat is taken
	always_ff @(posedge clk) begin
		if (state_q == pac_pkg::ST_OUT && can_load) begin
			twice_area   <= area_q;
			center_x     <= cx_q;
			center_y     <= cy_q;
			vertex_count <= count_q;
			overflow     <= overflow_seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pac_pkg::ST_OUT && can_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond limit");

	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == pac_pkg::ST_OUT))
		else $error("result beat raised outside load state");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		mac_ctl.clr |-> $past(state_q == pac_pkg::ST_DRAIN))
		else $error("accumulator cleared with products in flight");

endmodule

FILE: rtl/core/pac_mac.sv
// Shared multiply-accumulate unit: one registered signed product, then add or subtract
// into a wide accumulator. Depends on pac_pkg (mac_ctl_t).
module pac_mac #(
	parameter int CW    = 16,
	parameter int ACC_W = 41
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pac_pkg::mac_ctl_t       ctl,
	input  logic signed [CW-1:0]    op_a,
	input  logic signed [CW-1:0]    op_b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [2*CW-1:0]  prod_s1;
	logic                    en_s1;
	logic                    sub_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_ext;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1  <= 1'b0;
			sub_s1 <= 1'b0;
		end else begin
			en_s1  <= ctl.en;
			sub_s1 <= ctl.sub;
		end
	end

	assign prod_ext = {{(ACC_W-2*CW){prod_s1[2*CW-1]}}, prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (en_s1) begin
			acc_q <= sub_s1 ? (acc_q - prod_ext) : (acc_q + prod_ext);
		end
	end

	assign acc = acc_q;

endmodule

FILE: rtl/core/pac_div.sv
// Serial restoring divider: one quotient bit per cycle on the magnitude of a signed
// dividend. Returns the magnitude and the sign separately. Depends on pac_pkg (div_stat_t).
module pac_div #(
	parameter int SW    = 26,
	parameter int CNT_W = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [SW-1:0] dividend,
	input  logic [CNT_W-1:0]     divisor,
	output logic [SW-1:0]        quotient,
	output pac_pkg::div_stat_t   stat
);

	localparam int IT_W = $clog2(SW + 1);

	logic [SW-1:0]    quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] d_q;
	logic [IT_W-1:0]  it_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W:0]   shifted;
	logic [CNT_W:0]   diff;
	logic             fits;
	logic [SW-1:0]    dividend_mag;

	assign dividend_mag = dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
	assign shifted      = {rem_q, quo_q[SW-1]};
	assign diff         = shifted - {1'b0, d_q};
	assign fits         = (shifted >= {1'b0, d_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend_mag;
			rem_q <= '0;
			d_q   <= divisor;
			neg_q <= dividend[SW-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[SW-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q   <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				it_q   <= IT_W'(SW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				it_q <= it_q - IT_W'(1);
				if (it_q == IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.neg  = neg_q;

endmodule
